// File: src/assert_macros.svh
// Assertion helpers used by fbl_ctrl.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication.
`define FBL_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("fbl assertion failed");
// Next-cycle implication.
`define FBL_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("fbl assertion failed");
`else
`define FBL_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define FBL_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif
`endif

// File: src/fbl_pkg.sv
package fbl_pkg;

   localparam int NUM_BLOCKS   = 1024;
   localparam int NUM_SEGMENTS = 16;
   localparam int NODE_TOTAL   = NUM_BLOCKS + NUM_SEGMENTS + 1;
   localparam int NODE_W       = $clog2(NODE_TOTAL);
   localparam int BLK_W        = $clog2(NUM_BLOCKS);
   localparam int SEG_W        = $clog2(NUM_SEGMENTS);
   localparam int LS_W         = $clog2(NUM_SEGMENTS + 1);
   localparam int CNT_W        = $clog2(NUM_BLOCKS + 1);
   localparam int LEN_W        = 7;
   localparam int ACT_W        = 2;

   localparam logic [LEN_W-1:0]  LEN_RESET = LEN_W'(64);
   localparam logic [NODE_W-1:0] HEAD_NODE = NODE_W'(NUM_BLOCKS + NUM_SEGMENTS);
   localparam logic [NODE_W-1:0] CLR_LAST  = NODE_W'(NODE_TOTAL - 1);
   localparam logic [NODE_W-1:0] BLK_LIMIT = NODE_W'(NUM_BLOCKS);

   typedef enum logic [ACT_W-1:0] {
      ACT_APPEND,
      ACT_ALLOC,
      ACT_FREE,
      ACT_REMOVE
   } action_type;

   typedef enum logic [4:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DET_CHK,
      ST_DET_SELF,
      ST_APP_TAIL,
      ST_APP_AT,
      ST_PA_W1,
      ST_PA_W2,
      ST_APP_FIN,
      ST_FRE_START,
      ST_FRE_FIN,
      ST_ALC_CHK,
      ST_CUT_W1,
      ST_RM_MOV,
      ST_RM_MCUT,
      ST_RM_MSELF,
      ST_RM_BRD,
      ST_RM_LINK1,
      ST_RM_LINK2,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic [NODE_W-1:0] rd_addr;
      logic              n_we;
      logic [NODE_W-1:0] n_waddr;
      logic [NODE_W-1:0] n_wdata;
      logic              p_we;
      logic [NODE_W-1:0] p_waddr;
      logic [NODE_W-1:0] p_wdata;
      logic              o_we;
      logic [BLK_W-1:0]  o_waddr;
      logic [SEG_W-1:0]  o_wdata;
   } mem_cmd_type;

   typedef struct packed {
      logic [BLK_W-1:0] granted;
      logic             status;
      logic [SEG_W-1:0] segment;
      logic [CNT_W-1:0] count;
   } result_type;

   function automatic logic [NODE_W-1:0] sentinel(input logic [SEG_W-1:0] seg);
      return BLK_LIMIT + NODE_W'(seg);
   endfunction

   function automatic logic [SEG_W-1:0] seg_next(input logic [SEG_W-1:0] seg);
      return (seg == SEG_W'(NUM_SEGMENTS - 1)) ? '0 : seg + SEG_W'(1);
   endfunction

endpackage

// File: src/fbl_ram.sv
module fbl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

// File: src/fbl_ctrl.sv
`include "assert_macros.svh"

module fbl_ctrl import fbl_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [ACT_W-1:0]  req_action,
   input  logic [BLK_W-1:0]  req_block,
   input  logic [LEN_W-1:0]  seg_len,
   output mem_cmd_type       mem_cmd,
   input  logic [NODE_W-1:0] n_rdata,
   input  logic [NODE_W-1:0] p_rdata,
   input  logic [SEG_W-1:0]  o_rdata,
   output logic              res_valid,
   input  logic              res_ready,
   output result_type        res
);

   state_type         state_ff, state_in;
   action_type        act_ff, act_in;
   logic [BLK_W-1:0]  blk_ff, blk_in;
   logic [BLK_W-1:0]  mov_ff, mov_in;
   logic [NODE_W-1:0] node_ff, node_in;
   logic [NODE_W-1:0] at_ff, at_in;
   logic [NODE_W-1:0] x_ff, x_in;
   logic [SEG_W-1:0]  own_ff, own_in;
   logic [SEG_W-1:0]  seg_ff, seg_in;
   logic [BLK_W-1:0]  gnt_ff, gnt_in;
   logic              sts_ff, sts_in;
   logic              place_ff, place_in;
   logic [SEG_W-1:0]  cur_ff, cur_in;
   logic [LS_W-1:0]   ls_ff, ls_in;
   logic [LEN_W-1:0]  lis_ff, lis_in;
   logic [NODE_W-1:0] clr_ff, clr_in;
   logic [CNT_W-1:0]  counts_ff [NUM_SEGMENTS];
   logic [CNT_W-1:0]  counts_in [NUM_SEGMENTS];

   logic [SEG_W-1:0]  cnt_idx;
   logic [CNT_W-1:0]  cnt_cur;
   logic              cnt_dec, cnt_inc;
   logic [NODE_W-1:0] blk_node;
   logic [LEN_W-1:0]  len_eff;
   logic [LEN_W-1:0]  lis_sum;
   logic              ls_open;

   assign blk_node = NODE_W'(blk_ff);
   assign ls_open  = (ls_ff < LS_W'(NUM_SEGMENTS));
   assign len_eff  = (seg_len == '0) ? LEN_W'(1) : seg_len;
   assign lis_sum  = lis_ff + LEN_W'(1);
   assign cnt_idx  = (state_ff == ST_DET_CHK) ? o_rdata : seg_ff;
   assign cnt_cur  = counts_ff[cnt_idx];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff   <= '0;
         cur_ff   <= '0;
         ls_ff    <= '0;
         lis_ff   <= '0;
         place_ff <= 1'b0;
         for (int i = 0; i < NUM_SEGMENTS; i++) begin
            counts_ff[i] <= '0;
         end
      end else begin
         state_ff  <= state_in;
         clr_ff    <= clr_in;
         cur_ff    <= cur_in;
         ls_ff     <= ls_in;
         lis_ff    <= lis_in;
         place_ff  <= place_in;
         counts_ff <= counts_in;
      end
   end

   always_ff @(posedge clock) begin
      act_ff  <= act_in;
      blk_ff  <= blk_in;
      mov_ff  <= mov_in;
      node_ff <= node_in;
      at_ff   <= at_in;
      x_ff    <= x_in;
      own_ff  <= own_in;
      seg_ff  <= seg_in;
      gnt_ff  <= gnt_in;
      sts_ff  <= sts_in;
   end

   always_comb begin
      logic [SEG_W-1:0] fseg;
      state_in  = state_ff;
      act_in    = act_ff;
      blk_in    = blk_ff;
      mov_in    = mov_ff;
      node_in   = node_ff;
      at_in     = at_ff;
      x_in      = x_ff;
      own_in    = own_ff;
      seg_in    = seg_ff;
      gnt_in    = gnt_ff;
      sts_in    = sts_ff;
      place_in  = place_ff;
      cur_in    = cur_ff;
      ls_in     = ls_ff;
      lis_in    = lis_ff;
      clr_in    = clr_ff;
      counts_in = counts_ff;
      cnt_dec   = 1'b0;
      cnt_inc   = 1'b0;
      req_ready = 1'b0;
      res_valid = 1'b0;
      fseg      = (cur_ff == '0) ? SEG_W'(NUM_SEGMENTS - 1) : cur_ff - SEG_W'(1);
      mem_cmd   = '0;

      case (state_ff)
         ST_CLEAR: begin
            mem_cmd.n_we    = 1'b1;
            mem_cmd.n_waddr = clr_ff;
            mem_cmd.n_wdata = clr_ff;
            mem_cmd.p_we    = 1'b1;
            mem_cmd.p_waddr = clr_ff;
            mem_cmd.p_wdata = clr_ff;
            clr_in          = clr_ff + NODE_W'(1);
            if (clr_ff == CLR_LAST) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            act_in    = action_type'(req_action);
            blk_in    = req_block;
            gnt_in    = req_block;
            sts_in    = 1'b0;
            seg_in    = cur_ff;
            place_in  = 1'b0;
            if (action_type'(req_action) == ACT_ALLOC) begin
               mem_cmd.rd_addr = sentinel(cur_ff);
            end else begin
               mem_cmd.rd_addr = NODE_W'(req_block);
            end
            if (action_type'(req_action) == ACT_APPEND) begin
               seg_in   = ls_open ? ls_ff[SEG_W-1:0] : SEG_W'(NUM_SEGMENTS - 1);
               place_in = ls_open && (lis_ff == '0);
            end
            if (req_valid) begin
               state_in = (action_type'(req_action) == ACT_ALLOC) ? ST_ALC_CHK
                                                                  : ST_DET_CHK;
            end
         end
         ST_DET_CHK: begin
            x_in   = n_rdata;
            own_in = o_rdata;
            if (act_ff == ACT_REMOVE) begin
               if (n_rdata == blk_node) begin
                  state_in = ST_OUT;
               end else if (o_rdata == seg_ff) begin
                  cnt_dec         = 1'b1;
                  mem_cmd.n_we    = 1'b1;
                  mem_cmd.n_waddr = p_rdata;
                  mem_cmd.n_wdata = n_rdata;
                  mem_cmd.p_we    = 1'b1;
                  mem_cmd.p_waddr = n_rdata;
                  mem_cmd.p_wdata = p_rdata;
                  cur_in          = seg_next(seg_ff);
                  state_in        = ST_DET_SELF;
               end else begin
                  mem_cmd.rd_addr = sentinel(seg_ff);
                  state_in        = ST_RM_MOV;
               end
            end else if (n_rdata != blk_node) begin
               cnt_dec         = 1'b1;
               mem_cmd.n_we    = 1'b1;
               mem_cmd.n_waddr = p_rdata;
               mem_cmd.n_wdata = n_rdata;
               mem_cmd.p_we    = 1'b1;
               mem_cmd.p_waddr = n_rdata;
               mem_cmd.p_wdata = p_rdata;
               state_in        = ST_DET_SELF;
            end else begin
               state_in = (act_ff == ACT_APPEND) ? ST_APP_TAIL : ST_FRE_START;
            end
         end
         ST_DET_SELF: begin
            mem_cmd.n_we    = 1'b1;
            mem_cmd.n_waddr = blk_node;
            mem_cmd.n_wdata = blk_node;
            mem_cmd.p_we    = 1'b1;
            mem_cmd.p_waddr = blk_node;
            mem_cmd.p_wdata = blk_node;
            case (act_ff)
               ACT_APPEND: state_in = ST_APP_TAIL;
               ACT_FREE:   state_in = ST_FRE_START;
               default:    state_in = ST_OUT;
            endcase
         end
         ST_APP_TAIL: begin
            mem_cmd.rd_addr = HEAD_NODE;
            state_in        = ST_APP_AT;
         end
         ST_APP_AT: begin
            at_in           = p_rdata;
            mem_cmd.rd_addr = p_rdata;
            node_in         = place_ff ? sentinel(ls_ff[SEG_W-1:0]) : blk_node;
            state_in        = ST_PA_W1;
         end
         ST_FRE_START: begin
            seg_in          = fseg;
            cur_in          = fseg;
            at_in           = sentinel(fseg);
            node_in         = blk_node;
            mem_cmd.rd_addr = sentinel(fseg);
            state_in        = ST_PA_W1;
         end
         ST_PA_W1: begin
            x_in            = n_rdata;
            mem_cmd.n_we    = 1'b1;
            mem_cmd.n_waddr = node_ff;
            mem_cmd.n_wdata = n_rdata;
            mem_cmd.p_we    = 1'b1;
            mem_cmd.p_waddr = node_ff;
            mem_cmd.p_wdata = at_ff;
            state_in        = ST_PA_W2;
         end
         ST_PA_W2: begin
            mem_cmd.p_we    = 1'b1;
            mem_cmd.p_waddr = x_ff;
            mem_cmd.p_wdata = node_ff;
            mem_cmd.n_we    = 1'b1;
            mem_cmd.n_waddr = at_ff;
            mem_cmd.n_wdata = node_ff;
            if (act_ff == ACT_APPEND) begin
               place_in = 1'b0;
               state_in = place_ff ? ST_APP_TAIL : ST_APP_FIN;
            end else begin
               state_in = ST_FRE_FIN;
            end
         end
         ST_APP_FIN: begin
            mem_cmd.o_we    = 1'b1;
            mem_cmd.o_waddr = blk_ff;
            mem_cmd.o_wdata = seg_ff;
            cnt_inc         = 1'b1;
            if (ls_open) begin
               if (lis_sum >= len_eff) begin
                  lis_in = '0;
                  ls_in  = ls_ff + LS_W'(1);
               end else begin
                  lis_in = lis_sum;
               end
            end
            state_in = ST_OUT;
         end
         ST_FRE_FIN: begin
            mem_cmd.o_we    = 1'b1;
            mem_cmd.o_waddr = blk_ff;
            mem_cmd.o_wdata = seg_ff;
            cnt_inc         = 1'b1;
            state_in        = ST_OUT;
         end
         ST_ALC_CHK: begin
            if (n_rdata < BLK_LIMIT) begin
               blk_in          = n_rdata[BLK_W-1:0];
               gnt_in          = n_rdata[BLK_W-1:0];
               mem_cmd.rd_addr = n_rdata;
               state_in        = ST_CUT_W1;
            end else begin
               sts_in   = 1'b1;
               state_in = ST_OUT;
            end
         end
         ST_CUT_W1: begin
            mem_cmd.n_we    = 1'b1;
            mem_cmd.n_waddr = p_rdata;
            mem_cmd.n_wdata = n_rdata;
            mem_cmd.p_we    = 1'b1;
            mem_cmd.p_waddr = n_rdata;
            mem_cmd.p_wdata = p_rdata;
            cnt_dec         = 1'b1;
            cur_in          = seg_next(seg_ff);
            state_in        = ST_DET_SELF;
         end
         ST_RM_MOV: begin
            if (n_rdata < BLK_LIMIT) begin
               mov_in          = n_rdata[BLK_W-1:0];
               mem_cmd.rd_addr = n_rdata;
               state_in        = ST_RM_MCUT;
            end else begin
               sts_in   = 1'b1;
               state_in = ST_OUT;
            end
         end
         ST_RM_MCUT: begin
            mem_cmd.n_we    = 1'b1;
            mem_cmd.n_waddr = p_rdata;
            mem_cmd.n_wdata = n_rdata;
            mem_cmd.p_we    = 1'b1;
            mem_cmd.p_waddr = n_rdata;
            mem_cmd.p_wdata = p_rdata;
            cnt_dec         = 1'b1;
            state_in        = ST_RM_MSELF;
         end
         ST_RM_MSELF: begin
            mem_cmd.n_we    = 1'b1;
            mem_cmd.n_waddr = NODE_W'(mov_ff);
            mem_cmd.n_wdata = NODE_W'(mov_ff);
            mem_cmd.p_we    = 1'b1;
            mem_cmd.p_waddr = NODE_W'(mov_ff);
            mem_cmd.p_wdata = NODE_W'(mov_ff);
            state_in        = ST_RM_BRD;
         end
         ST_RM_BRD: begin
            mem_cmd.rd_addr = blk_node;
            state_in        = ST_RM_LINK1;
         end
         ST_RM_LINK1: begin
            x_in            = n_rdata;
            mem_cmd.n_we    = 1'b1;
            mem_cmd.n_waddr = p_rdata;
            mem_cmd.n_wdata = NODE_W'(mov_ff);
            mem_cmd.p_we    = 1'b1;
            mem_cmd.p_waddr = NODE_W'(mov_ff);
            mem_cmd.p_wdata = p_rdata;
            state_in        = ST_RM_LINK2;
         end
         ST_RM_LINK2: begin
            mem_cmd.n_we    = 1'b1;
            mem_cmd.n_waddr = NODE_W'(mov_ff);
            mem_cmd.n_wdata = x_ff;
            mem_cmd.p_we    = 1'b1;
            mem_cmd.p_waddr = x_ff;
            mem_cmd.p_wdata = NODE_W'(mov_ff);
            mem_cmd.o_we    = 1'b1;
            mem_cmd.o_waddr = mov_ff;
            mem_cmd.o_wdata = own_ff;
            cur_in          = seg_next(seg_ff);
            state_in        = ST_DET_SELF;
         end
         ST_OUT: begin
            res_valid = 1'b1;
            if (res_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // saturating per-segment count update
      if (cnt_dec && (cnt_cur != '0)) begin
         counts_in[cnt_idx] = cnt_cur - CNT_W'(1);
      end else if (cnt_inc && (cnt_cur < CNT_W'(NUM_BLOCKS))) begin
         counts_in[cnt_idx] = cnt_cur + CNT_W'(1);
      end
   end

   assign res.granted = gnt_ff;
   assign res.status  = sts_ff;
   assign res.segment = seg_ff;
   assign res.count   = cnt_cur;

   `FBL_ASSERT_IMP(a_cnt_cap, clock, reset, res_valid, cnt_cur <= CNT_W'(NUM_BLOCKS))
   `FBL_ASSERT_NXT(a_clr_done, clock, reset, state_ff == ST_CLEAR && clr_ff == CLR_LAST, state_ff == ST_IDLE)
   `FBL_ASSERT_NXT(a_res_hold, clock, reset, res_valid && !res_ready, res_valid && $stable(res))

endmodule

// File: src/segmented_free_block_list_top.sv
// Segmented free block list: free blocks in a circular doubly linked list,
// split into segments by sentinel nodes, served round-robin.
// req channel: one transaction per operation; tuser carries the action
//   (append, allocate, free, remove) and tdata the block index.
// rsp channel: exactly one transaction per request, in request order, with
//   the granted block, the segment used and that segment's free count in
//   tdata and the empty status in tuser.
// csr channel: writes the segment length; always ready. The user must write it
//   only while idle; the block itself does not enforce this.
// Each operation steps the sequencer through a series of states, set by the
//   single read and write port of each link memory; an append that places a
//   sentinel links the sentinel in before the block. rsp_tvalid rises in the
//   same cycle as req_tready, so the next request can be taken in that cycle.
// One request is processed at a time; the next is taken once the result is
//   parked in the rsp register.
// Reset: a clearing pass over all 1041 link nodes sets each to point to
//   itself; req_tready stays low until it ends.
// A stalled rsp receiver holds the result register; the sequencer then waits
//   with its result and takes no new request.
module segmented_free_block_list_top import fbl_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [15:0]            req_tdata,  // block[9:0]
   input  logic [ACT_W-1:0]       req_tuser,  // action[1:0]
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [31:0]            rsp_tdata,  // granted_block, segment, segment_count
   output logic                   rsp_tuser,  // status
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [LEN_W-1:0]       csr_data
);

   logic [LEN_W-1:0]  seg_len_ff;
   logic              rsp_valid_ff;
   result_type        rsp_ff;
   mem_cmd_type       mem_cmd;
   logic [NODE_W-1:0] n_rdata, p_rdata;
   logic [SEG_W-1:0]  o_rdata;
   logic              res_valid, res_ready;
   result_type        res;

   assign csr_ready = 1'b1;

   // segment length register
   always_ff @(posedge clock) begin
      if (reset) begin
         seg_len_ff <= LEN_RESET;
      end else if (csr_valid) begin
         seg_len_ff <= csr_data;
      end
   end

   // output register: loads when empty or being drained
   assign res_ready = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (res_ready) begin
         rsp_valid_ff <= res_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (res_ready && res_valid) begin
         rsp_ff <= res;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_ff.status;
   assign rsp_tdata  = {7'd0, rsp_ff.count, rsp_ff.segment, rsp_ff.granted};

   fbl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .req_action(req_tuser),
      .req_block (req_tdata[BLK_W-1:0]),
      .seg_len   (seg_len_ff),
      .mem_cmd   (mem_cmd),
      .n_rdata   (n_rdata),
      .p_rdata   (p_rdata),
      .o_rdata   (o_rdata),
      .res_valid (res_valid),
      .res_ready (res_ready),
      .res       (res)
   );

   // forward links
   fbl_ram #(.WIDTH(NODE_W), .DEPTH(NODE_TOTAL)) u_next_ram (
      .clock  (clock),
      .wr_en  (mem_cmd.n_we),
      .wr_addr(mem_cmd.n_waddr),
      .wr_data(mem_cmd.n_wdata),
      .rd_addr(mem_cmd.rd_addr),
      .rd_data(n_rdata)
   );

   // backward links
   fbl_ram #(.WIDTH(NODE_W), .DEPTH(NODE_TOTAL)) u_prev_ram (
      .clock  (clock),
      .wr_en  (mem_cmd.p_we),
      .wr_addr(mem_cmd.p_waddr),
      .wr_data(mem_cmd.p_wdata),
      .rd_addr(mem_cmd.rd_addr),
      .rd_data(p_rdata)
   );

   // owning segment per block; its value is used only for linked blocks
   fbl_ram #(.WIDTH(SEG_W), .DEPTH(NUM_BLOCKS)) u_owner_ram (
      .clock  (clock),
      .wr_en  (mem_cmd.o_we),
      .wr_addr(mem_cmd.o_waddr),
      .wr_data(mem_cmd.o_wdata),
      .rd_addr(mem_cmd.rd_addr[BLK_W-1:0]),
      .rd_data(o_rdata)
   );

endmodule
